FILE: sv/mf3_pkg.sv
// ----------------------------------------------------------------------------
// mf3_pkg
// Shared constants and types of the 3x3 median filter.
// ----------------------------------------------------------------------------
package mf3_pkg;

  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int PIXEL_BITS_DEF = 8;

  localparam int PORT_PIX_BITS  = 8;    // pixel_in / pixel_out port width
  localparam int CFG_W_BITS     = 11;   // image_width register
  localparam int CFG_H_BITS     = 13;   // image_height register
  localparam int ROW_BITS       = 13;   // row counters, reach height + 1
  localparam int MAX_HEIGHT     = 4096;

  localparam logic [CFG_W_BITS-1:0] WIDTH_RST  = CFG_W_BITS'(1024);
  localparam logic [CFG_H_BITS-1:0] HEIGHT_RST = CFG_H_BITS'(768);

  localparam int APB_ADDR_BITS = 3;
  localparam int APB_DATA_BITS = 32;

  // register index, taken from paddr[2]
  localparam logic REG_IMAGE_WIDTH  = 1'b0;
  localparam logic REG_IMAGE_HEIGHT = 1'b1;

  localparam logic MODE_PIXEL = 1'b0;
  localparam logic MODE_FLUSH = 1'b1;

  localparam int MID_DEPTH = 4;
  localparam int OUT_DEPTH = 8;

  // per-step control handed from the front to the back
  typedef struct packed {
    logic emit;     // step produces a result
    logic border;   // result is the unfiltered center pixel
    logic last;     // result closes the frame
  } mf3_ctrl_t;

  typedef struct packed {
    logic [PORT_PIX_BITS-1:0] pixel_out;
    logic                     frame_end;
  } mf3_result_t;

endpackage

FILE: sv/mf3_fifo.sv
// ----------------------------------------------------------------------------
// mf3_fifo
// Small register-based queue with occupancy count.
// ----------------------------------------------------------------------------
module mf3_fifo #(
  parameter int DEPTH  = 4,
  parameter int DATA_W = 8
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  logic [DATA_W-1:0]          wr_data,
  output logic                       full,
  input  logic                       pop,
  output logic [DATA_W-1:0]          rd_data,
  output logic                       empty,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] store [DEPTH];
  logic [AW-1:0]     wr_ptr;
  logic [AW-1:0]     rd_ptr;
  logic              push_ok;
  logic              pop_ok;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign push_ok = push && !full;
  assign pop_ok  = pop && !empty;
  assign rd_data = store[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push_ok) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (pop_ok) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      case ({push_ok, pop_ok})
        2'b10: count <= count + CW'(1);
        2'b01: count <= count - CW'(1);
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      store[wr_ptr] <= wr_data;
    end
  end

endmodule

FILE: sv/mf3_front.sv
// ----------------------------------------------------------------------------
// mf3_front
// Raster position tracking: drops idle flushes, restarts frames and tags
// each step with its line store column and result class.
// ----------------------------------------------------------------------------
module mf3_front
  import mf3_pkg::*;
#(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int PIXEL_BITS = PIXEL_BITS_DEF,
  localparam int COL_BITS  = $clog2(MAX_WIDTH),
  localparam int EW = (CFG_W_BITS > $clog2(MAX_WIDTH + 1)) ? CFG_W_BITS
                                                           : $clog2(MAX_WIDTH + 1)
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_restart,
  input  logic [EW-1:0]            width_eff,
  input  logic [ROW_BITS-1:0]      height_eff,
  input  logic                     in_valid,
  input  logic                     mode,
  input  logic [PORT_PIX_BITS-1:0] pixel_in,
  output logic                     step_valid,
  output logic [PIXEL_BITS-1:0]    step_pix,
  output logic [COL_BITS-1:0]      step_col,
  output mf3_ctrl_t                step_ctrl
);

  logic [COL_BITS-1:0] in_column, in_column_next;
  logic [ROW_BITS-1:0] in_row, in_row_next;
  logic [COL_BITS-1:0] out_column, out_column_next;
  logic [ROW_BITS-1:0] out_row, out_row_next;

  logic                flush, drop, restart, step;
  logic [COL_BITS-1:0] ic, oc;
  logic [ROW_BITS-1:0] ir, orow;
  logic [EW-1:0]       ic_inc, oc_inc, oc_ext;
  logic                emit, row_last, col_last, border, last;

  always_comb begin
    flush   = (mode == MODE_FLUSH);
    drop    = flush && (in_row < height_eff);
    restart = !flush && (in_row >= height_eff);   // pixel after a complete frame
    step    = in_valid && !drop;

    ic   = restart ? '0 : in_column;
    ir   = restart ? '0 : in_row;
    oc   = restart ? '0 : out_column;
    orow = restart ? '0 : out_row;

    ic_inc = EW'(ic) + EW'(1);
    oc_ext = EW'(oc);
    oc_inc = oc_ext + EW'(1);

    emit     = (ir >= ROW_BITS'(2)) || ((ir == ROW_BITS'(1)) && (ic != '0));
    row_last = (orow >= height_eff - ROW_BITS'(1));
    col_last = (oc_ext >= width_eff - EW'(1));
    border   = (orow == '0) || row_last || (oc == '0) || col_last;
    last     = row_last && col_last;

    in_column_next  = in_column;
    in_row_next     = in_row;
    out_column_next = out_column;
    out_row_next    = out_row;

    if (step) begin
      if (ic_inc >= width_eff) begin
        in_column_next = '0;
        in_row_next    = ir + ROW_BITS'(1);
      end else begin
        in_column_next = COL_BITS'(ic_inc);
        in_row_next    = ir;
      end
      out_column_next = oc;
      out_row_next    = orow;
      if (emit) begin
        if (last) begin
          in_column_next  = '0;
          in_row_next     = '0;
          out_column_next = '0;
          out_row_next    = '0;
        end else if (oc_inc >= width_eff) begin
          out_column_next = '0;
          out_row_next    = orow + ROW_BITS'(1);
        end else begin
          out_column_next = COL_BITS'(oc_inc);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_restart) begin
      in_column  <= '0;
      in_row     <= '0;
      out_column <= '0;
      out_row    <= '0;
    end else begin
      in_column  <= in_column_next;
      in_row     <= in_row_next;
      out_column <= out_column_next;
      out_row    <= out_row_next;
    end
  end

  assign step_valid       = step;
  assign step_pix         = flush ? '0 : PIXEL_BITS'(pixel_in);
  assign step_col         = ic;
  assign step_ctrl.emit   = emit;
  assign step_ctrl.border = border;
  assign step_ctrl.last   = last;

endmodule

FILE: sv/mf3_back.sv
// ----------------------------------------------------------------------------
// mf3_back
// Line store, 3x3 window and pipelined median network with result queue.
// ----------------------------------------------------------------------------
module mf3_back
  import mf3_pkg::*;
#(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int PIXEL_BITS = PIXEL_BITS_DEF,
  localparam int COL_BITS  = $clog2(MAX_WIDTH)
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     mid_empty,
  input  logic [PIXEL_BITS-1:0]    mid_pix,
  input  logic [COL_BITS-1:0]      mid_col,
  input  mf3_ctrl_t                mid_ctrl,
  output logic                     mid_pop,
  input  logic                     pop,
  output logic                     empty,
  output logic [PORT_PIX_BITS-1:0] pixel_out,
  output logic                     frame_end
);

  localparam int PB  = PIXEL_BITS;
  localparam int OCW = $clog2(OUT_DEPTH + 1);

  function automatic logic [PB-1:0] min2(input logic [PB-1:0] a, input logic [PB-1:0] b);
    return (a < b) ? a : b;
  endfunction

  function automatic logic [PB-1:0] max2(input logic [PB-1:0] a, input logic [PB-1:0] b);
    return (a < b) ? b : a;
  endfunction

  function automatic logic [PB-1:0] med3(input logic [PB-1:0] a, input logic [PB-1:0] b,
                                         input logic [PB-1:0] c);
    return max2(min2(a, b), min2(max2(a, b), c));
  endfunction

  // line store entry: {row two back, row one back}
  logic [2*PB-1:0] line_mem [MAX_WIDTH];
  logic [2*PB-1:0] rd_data;

  logic [PB-1:0]   window [9];

  logic            v1, v2, v3, v4;
  logic [COL_BITS-1:0] p1_col;
  logic [PB-1:0]   p1_pix;
  mf3_ctrl_t       p1_ctrl, p2_ctrl, p3_ctrl, p4_ctrl;
  logic [PB-1:0]   p2_bval, p3_bval, p4_bval;
  logic [PB-1:0]   p3_lo [3];
  logic [PB-1:0]   p3_md [3];
  logic [PB-1:0]   p3_hi [3];
  logic [PB-1:0]   p4_a, p4_b, p4_c;

  logic [PB-1:0]   row_lo [3];
  logic [PB-1:0]   row_md [3];
  logic [PB-1:0]   row_hi [3];
  logic [PB-1:0]   med;
  logic [PB-1:0]   res_val;

  logic [OCW-1:0]  out_count;
  logic [2:0]      inflight;
  logic            credit_ok;
  logic            issue;
  logic            res_push;
  mf3_result_t     res, res_q;

  // only issue when the result queue has a slot for everything in flight
  assign inflight  = {2'b0, v1} + {2'b0, v2} + {2'b0, v3} + {2'b0, v4};
  assign credit_ok = ((OCW+1)'(out_count) + (OCW+1)'(inflight)) < (OCW+1)'(OUT_DEPTH);
  assign issue     = !mid_empty && credit_ok;
  assign mid_pop   = issue;

  always_ff @(posedge clk) begin
    if (issue) begin
      rd_data <= line_mem[mid_col];
    end
    if (v1) begin
      line_mem[p1_col] <= {rd_data[PB-1:0], p1_pix};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      for (int i = 0; i < 9; i++) begin
        window[i] <= '0;
      end
    end else begin
      v1 <= issue;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      if (v1) begin
        for (int r = 0; r < 3; r++) begin
          window[3*r]   <= window[3*r+1];
          window[3*r+1] <= window[3*r+2];
        end
        window[2] <= rd_data[2*PB-1:PB];
        window[5] <= rd_data[PB-1:0];
        window[8] <= p1_pix;
      end
    end
  end

  // sort each window row
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      row_lo[r] = min2(min2(window[3*r], window[3*r+1]), window[3*r+2]);
      row_hi[r] = max2(max2(window[3*r], window[3*r+1]), window[3*r+2]);
      row_md[r] = med3(window[3*r], window[3*r+1], window[3*r+2]);
    end
  end

  always_ff @(posedge clk) begin
    p1_col  <= mid_col;
    p1_pix  <= mid_pix;
    p1_ctrl <= mid_ctrl;

    // border value is the center pixel, i.e. the middle-right tap before the shift
    p2_ctrl <= p1_ctrl;
    p2_bval <= window[5];

    p3_ctrl <= p2_ctrl;
    p3_bval <= p2_bval;
    for (int r = 0; r < 3; r++) begin
      p3_lo[r] <= row_lo[r];
      p3_md[r] <= row_md[r];
      p3_hi[r] <= row_hi[r];
    end

    p4_ctrl <= p3_ctrl;
    p4_bval <= p3_bval;
    p4_a    <= max2(max2(p3_lo[0], p3_lo[1]), p3_lo[2]);
    p4_b    <= med3(p3_md[0], p3_md[1], p3_md[2]);
    p4_c    <= min2(min2(p3_hi[0], p3_hi[1]), p3_hi[2]);
  end

  assign med           = med3(p4_a, p4_b, p4_c);
  assign res_val       = p4_ctrl.border ? p4_bval : med;
  assign res.pixel_out = PORT_PIX_BITS'(res_val);
  assign res.frame_end = p4_ctrl.last;
  assign res_push      = v4 && p4_ctrl.emit;

  mf3_fifo #(
    .DEPTH  (OUT_DEPTH),
    .DATA_W ($bits(mf3_result_t))
  ) u_out_q (
    .clk     (clk),
    .rst     (rst),
    .push    (res_push),
    .wr_data (res),
    .full    (),
    .pop     (pop),
    .rd_data (res_q),
    .empty   (empty),
    .count   (out_count)
  );

  assign pixel_out = res_q.pixel_out;
  assign frame_end = res_q.frame_end;

endmodule

FILE: sv/median_filter_3x3_unit.sv
// ----------------------------------------------------------------------------
// median_filter_3x3_unit
// Streaming 3x3 median filter for grayscale raster frames.
// ----------------------------------------------------------------------------
// Input queue side: push with mode/pixel_in while full is low; one transfer per
// clock is sustained. A pixel item (mode 0) carries the next raster pixel, a
// flush item (mode 1) drains the pending results after the last pixel of a
// frame; effective (clamped) width + 1 flushes empty the pipe, idle flushes are discarded.
// Result queue side: pixel_out/frame_end are valid while empty is low and are
// taken with pop. frame_end marks the last pixel of the frame.
// Each result belongs to the pixel one line plus one pixel earlier; beyond
// that it passes step queue, line store read, window, row and median sorts
// and result queue. Throughput is one item per clock while the receiver keeps
// up, set by the line store, which takes one read and one write per cycle.
// When the receiver stalls, the 8-entry result queue fills, the back end stops
// issuing, the 4-entry step queue fills and full rises.
// Reset empties both queues, zeroes the window and the position counters and
// loads width 1024, height 768. Writing either APB register restarts the frame
// and must only be done with the block idle.
// ----------------------------------------------------------------------------
module median_filter_3x3_unit
  import mf3_pkg::*;
#(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int PIXEL_BITS = PIXEL_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  // configuration
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [APB_ADDR_BITS-1:0] paddr,
  input  logic [APB_DATA_BITS-1:0] pwdata,
  output logic [APB_DATA_BITS-1:0] prdata,
  output logic                     pready,
  // input items
  input  logic                     push,
  output logic                     full,
  input  logic                     mode,
  input  logic [PORT_PIX_BITS-1:0] pixel_in,
  // results
  input  logic                     pop,
  output logic                     empty,
  output logic [PORT_PIX_BITS-1:0] pixel_out,
  output logic                     frame_end
);

  localparam int COL_BITS = $clog2(MAX_WIDTH);
  localparam int EW = (CFG_W_BITS > $clog2(MAX_WIDTH + 1)) ? CFG_W_BITS
                                                          : $clog2(MAX_WIDTH + 1);
  localparam int MID_W = PIXEL_BITS + COL_BITS + $bits(mf3_ctrl_t);

  logic [CFG_W_BITS-1:0] image_width;
  logic [CFG_H_BITS-1:0] image_height;
  logic [EW-1:0]         width_ext;
  logic [EW-1:0]         width_eff;
  logic [ROW_BITS-1:0]   height_eff;
  logic                  cfg_wr;

  logic                  step_valid;
  logic [PIXEL_BITS-1:0] step_pix;
  logic [COL_BITS-1:0]   step_col;
  mf3_ctrl_t             step_ctrl;

  logic                  mid_full, mid_empty, mid_pop;
  logic [MID_W-1:0]      mid_wr, mid_rd;
  logic [PIXEL_BITS-1:0] mid_pix;
  logic [COL_BITS-1:0]   mid_col;
  mf3_ctrl_t             mid_ctrl;

  // ---- APB registers ----
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= WIDTH_RST;
      image_height <= HEIGHT_RST;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_IMAGE_WIDTH:  image_width  <= pwdata[CFG_W_BITS-1:0];
        REG_IMAGE_HEIGHT: image_height <= pwdata[CFG_H_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_IMAGE_WIDTH:  prdata = APB_DATA_BITS'(image_width);
      REG_IMAGE_HEIGHT: prdata = APB_DATA_BITS'(image_height);
      default:          prdata = '0;
    endcase
  end

  // clamp to the supported frame size
  assign width_ext = EW'(image_width);

  always_comb begin
    if (width_ext < EW'(3)) begin
      width_eff = EW'(3);
    end else if (width_ext > EW'(MAX_WIDTH)) begin
      width_eff = EW'(MAX_WIDTH);
    end else begin
      width_eff = width_ext;
    end

    if (image_height < CFG_H_BITS'(3)) begin
      height_eff = ROW_BITS'(3);
    end else if (image_height > CFG_H_BITS'(MAX_HEIGHT)) begin
      height_eff = ROW_BITS'(MAX_HEIGHT);
    end else begin
      height_eff = ROW_BITS'(image_height);
    end
  end

  // ---- front: position tracking ----
  assign full = mid_full;

  mf3_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_restart (cfg_wr),
    .width_eff   (width_eff),
    .height_eff  (height_eff),
    .in_valid    (push && !mid_full),
    .mode        (mode),
    .pixel_in    (pixel_in),
    .step_valid  (step_valid),
    .step_pix    (step_pix),
    .step_col    (step_col),
    .step_ctrl   (step_ctrl)
  );

  // ---- step queue between front and back ----
  assign mid_wr = {step_pix, step_col, step_ctrl};

  mf3_fifo #(
    .DEPTH  (MID_DEPTH),
    .DATA_W (MID_W)
  ) u_mid_q (
    .clk     (clk),
    .rst     (rst),
    .push    (step_valid),
    .wr_data (mid_wr),
    .full    (mid_full),
    .pop     (mid_pop),
    .rd_data (mid_rd),
    .empty   (mid_empty),
    .count   ()
  );

  assign {mid_pix, mid_col, mid_ctrl} = mid_rd;

  // ---- back: window and median ----
  mf3_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .mid_empty (mid_empty),
    .mid_pix   (mid_pix),
    .mid_col   (mid_col),
    .mid_ctrl  (mid_ctrl),
    .mid_pop   (mid_pop),
    .pop       (pop),
    .empty     (empty),
    .pixel_out (pixel_out),
    .frame_end (frame_end)
  );

endmodule
